// ===== rtl/core/aces_pkg.sv =====
// Shared types, constants and rounding helper for the ACES luma pipeline.
// No dependencies; imported by aces_lane and aces_synthetic_exposure_luma.
`timescale 1ns / 1ps

package aces_pkg;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [15:0] luma_highlights;
        logic [15:0] luma_midtones;
        logic [15:0] luma_shadows;
    } luma_t;

    typedef enum logic [1:0] {
        REG_EXPOSURE  = 2'd0,
        REG_HIGHLIGHT = 2'd1,
        REG_SHADOW    = 2'd2
    } reg_index_t;

    // datapath widths
    localparam int CH_W     = 16;
    localparam int GAIN_W   = 17;
    localparam int SHADOW_W = 15;
    localparam int BASE_W   = CH_W + 1 + GAIN_W - 1;   // channel x exposure
    localparam int MUL_W    = BASE_W + GAIN_W;         // x copy gain
    localparam int CV_W     = 29;                      // scaled / matrixed value
    localparam int COEF_W   = 18;
    localparam int IP_W     = CV_W + COEF_W;
    localparam int A_W      = 60;                      // curve numerator / denominator
    localparam int DIV_W    = A_W + 16;
    localparam int QUO_W    = 18;
    localparam int F_W      = QUO_W + 1;
    localparam int OP_W     = F_W + COEF_W;
    localparam int O_W      = 17;
    localparam int Y_W      = 33;
    localparam int ROOT_W   = 17;
    localparam int REM_W    = 35;

    // lane stage count: front end 8, divider, 5 middle, root, output
    localparam int LANE_STAGES = 8 + QUO_W + 5 + ROOT_W + 1;
    localparam int PIPE_STAGES = LANE_STAGES + 1;

    localparam logic signed [GAIN_W-1:0] UNITY_GAIN      = 17'sd4096;
    localparam logic signed [GAIN_W-1:0] EXPOSURE_RESET  = 17'sd4096;
    localparam logic signed [GAIN_W-1:0] HIGHLIGHT_RESET = 17'sd8192;
    localparam logic signed [SHADOW_W-1:0] SHADOW_RESET  = 15'sd2048;

    localparam logic signed [31:0] CURVE_A1 = 32'sd1611;
    localparam logic signed [31:0] CURVE_A0 = 32'sd388853;
    localparam logic signed [31:0] CURVE_B2 = 32'sd64470;
    localparam logic signed [31:0] CURVE_B1 = 32'sd28374;
    localparam logic signed [31:0] CURVE_B0 = 32'sd1022550109;

    typedef logic signed [COEF_W-1:0] coef_t;

    localparam coef_t IN_MAT [3][3] = '{
        '{18'sd39137, 18'sd23238, 18'sd3161},
        '{18'sd4981,  18'sd59529, 18'sd1026},
        '{18'sd1861,  18'sd8771,  18'sd54904}
    };

    localparam coef_t OUT_MAT [3][3] = '{
        '{18'sd105169, -18'sd34805, -18'sd4828},
        '{-18'sd6690,  18'sd72622,  -18'sd396},
        '{-18'sd214,   -18'sd4768,  18'sd70518}
    };

    localparam logic [15:0] LUMA_W [3] = '{16'd6554, 16'd45875, 16'd13107};

    // shift right by n (n >= 1), rounding half away from zero
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                      input int unsigned n);
        logic [63:0] half;
        logic [63:0] mag;
        half = 64'd1 << (n - 1);
        mag  = x[63] ? 64'(-x) : 64'(x);
        mag  = (mag + half) >> n;
        rnd_shift = x[63] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

// ===== rtl/core/aces_lane.sv =====
// One exposure copy: gain, input matrix, filmic curve with pipelined divider,
// output matrix, clamp, luma and pipelined square root. Uses aces_pkg.
`timescale 1ns / 1ps

module aces_lane
    import aces_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [BASE_W-1:0] base [3],
    input  logic signed [GAIN_W-1:0] gain,
    output logic [15:0]              luma
);

    logic signed [MUL_W-1:0] m_reg [3];
    logic signed [MUL_W-1:0] m_next [3];
    logic signed [CV_W-1:0]  c_reg [3];
    logic signed [CV_W-1:0]  c_next [3];
    logic signed [IP_W-1:0]  ip_reg [3][3];
    logic signed [IP_W-1:0]  ip_next [3][3];
    logic signed [CV_W-1:0]  v_reg [3];
    logic signed [CV_W-1:0]  v_next [3];
    logic signed [CV_W-1:0]  v1_reg [3];
    logic signed [CV_W-1:0]  v2_reg [3];
    logic signed [A_W-1:0]   p_reg [3];
    logic signed [A_W-1:0]   p_next [3];
    logic signed [A_W-1:0]   t_reg [3];
    logic signed [A_W-1:0]   t_next [3];
    logic signed [A_W-1:0]   a_reg [3];
    logic signed [A_W-1:0]   a_next [3];
    logic signed [A_W-1:0]   tr_reg [3];
    logic signed [A_W-1:0]   tr_next [3];
    logic signed [A_W-1:0]   a2_reg [3];
    logic signed [A_W-1:0]   bp_reg [3];
    logic signed [A_W-1:0]   bp_next [3];

    logic [DIV_W-1:0]        dv_r_reg [QUO_W+1][3];
    logic [DIV_W-1:0]        dv_r_next [QUO_W+1][3];
    logic [DIV_W-1:0]        dv_b_reg [QUO_W+1][3];
    logic [DIV_W-1:0]        dv_b_next [QUO_W+1][3];
    logic [QUO_W-1:0]        dv_q_reg [QUO_W+1][3];
    logic [QUO_W-1:0]        dv_q_next [QUO_W+1][3];
    logic                    dv_neg_reg [QUO_W+1][3];
    logic                    dv_neg_next [QUO_W+1][3];

    logic signed [F_W-1:0]   f_reg [3];
    logic signed [F_W-1:0]   f_next [3];
    logic signed [OP_W-1:0]  op_reg [3][3];
    logic signed [OP_W-1:0]  op_next [3][3];
    logic [O_W-1:0]          o_reg [3];
    logic [O_W-1:0]          o_next [3];
    logic [Y_W-1:0]          lp_reg [3];
    logic [Y_W-1:0]          lp_next [3];

    logic [REM_W-1:0]        sq_rem_reg [ROOT_W+1];
    logic [REM_W-1:0]        sq_rem_next [ROOT_W+1];
    logic [ROOT_W-1:0]       sq_root_reg [ROOT_W+1];
    logic [ROOT_W-1:0]       sq_root_next [ROOT_W+1];
    logic [15:0]             luma_reg;
    logic [15:0]             luma_next;

    // gain, input matrix, curve numerator and denominator terms
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            m_next[c] = base[c] * gain;
            c_next[c] = CV_W'(rnd_shift(64'(m_reg[c]), 20));
            for (int k = 0; k < 3; k++)
            begin
                ip_next[c][k] = IN_MAT[c][k] * c_reg[k];
            end
            v_next[c] = CV_W'(rnd_shift(64'(ip_reg[c][0]) + 64'(ip_reg[c][1])
                                        + 64'(ip_reg[c][2]), 16));
            p_next[c]  = A_W'(v_reg[c]) * (A_W'(v_reg[c]) + A_W'(CURVE_A1));
            t_next[c]  = A_W'(v_reg[c]) * A_W'(CURVE_B2);
            a_next[c]  = p_reg[c] - A_W'(CURVE_A0);
            tr_next[c] = A_W'(rnd_shift(64'(t_reg[c]), 16)) + A_W'(CURVE_B1);
            bp_next[c] = A_W'(v2_reg[c]) * tr_reg[c];
        end
    end

    // divider setup and restoring steps, one quotient bit per stage
    always_comb
    begin
        logic signed [A_W-1:0] b_sum;
        logic [A_W-1:0]        ua;
        logic [DIV_W-1:0]      sh;
        logic [DIV_W-1:0]      r;
        logic [QUO_W-1:0]      q;
        for (int c = 0; c < 3; c++)
        begin
            b_sum = bp_reg[c] + A_W'(CURVE_B0);
            if (b_sum[A_W-1] || (b_sum == '0))
            begin
                b_sum = A_W'(1);
            end
            ua = a2_reg[c][A_W-1] ? A_W'(-a2_reg[c]) : A_W'(a2_reg[c]);
            dv_r_next[0][c]   = DIV_W'(ua) << 16;
            dv_b_next[0][c]   = DIV_W'(unsigned'(b_sum));
            dv_q_next[0][c]   = '0;
            dv_neg_next[0][c] = a2_reg[c][A_W-1];
            for (int j = 0; j < QUO_W; j++)
            begin
                sh = dv_b_reg[j][c] << (QUO_W - 1 - j);
                r  = dv_r_reg[j][c];
                q  = dv_q_reg[j][c];
                if (r >= sh)
                begin
                    r = r - sh;
                    q[QUO_W-1-j] = 1'b1;
                end
                dv_r_next[j+1][c]   = r;
                dv_b_next[j+1][c]   = dv_b_reg[j][c];
                dv_q_next[j+1][c]   = q;
                dv_neg_next[j+1][c] = dv_neg_reg[j][c];
            end
        end
    end

    // output matrix, clamp, luma weights
    always_comb
    begin
        logic signed [63:0] s;
        for (int c = 0; c < 3; c++)
        begin
            f_next[c] = dv_neg_reg[QUO_W][c] ? -$signed({1'b0, dv_q_reg[QUO_W][c]})
                                             : $signed({1'b0, dv_q_reg[QUO_W][c]});
            for (int k = 0; k < 3; k++)
            begin
                op_next[c][k] = OUT_MAT[c][k] * f_reg[k];
            end
            s = rnd_shift(64'(op_reg[c][0]) + 64'(op_reg[c][1]) + 64'(op_reg[c][2]), 16);
            if (s[63])
            begin
                o_next[c] = '0;
            end
            else if (s > 64'sd65536)
            begin
                o_next[c] = O_W'(65536);
            end
            else
            begin
                o_next[c] = O_W'(s);
            end
            lp_next[c] = Y_W'(LUMA_W[c]) * Y_W'(o_reg[c]);
        end
    end

    // luma sum and digit-by-digit square root, rem = y - root^2
    always_comb
    begin
        logic [REM_W-1:0] d;
        sq_rem_next[0]  = REM_W'(lp_reg[0]) + REM_W'(lp_reg[1]) + REM_W'(lp_reg[2]);
        sq_root_next[0] = '0;
        for (int j = 0; j < ROOT_W; j++)
        begin
            d = (REM_W'(sq_root_reg[j]) << (ROOT_W - j))
                + (REM_W'(1) << (2 * (ROOT_W - 1 - j)));
            sq_rem_next[j+1]  = sq_rem_reg[j];
            sq_root_next[j+1] = sq_root_reg[j];
            if (sq_rem_reg[j] >= d)
            begin
                sq_rem_next[j+1] = sq_rem_reg[j] - d;
                sq_root_next[j+1][ROOT_W-1-j] = 1'b1;
            end
        end
        luma_next = sq_root_reg[ROOT_W][ROOT_W-1] ? 16'hFFFF
                                                  : sq_root_reg[ROOT_W][15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                m_reg[c]  <= m_next[c];
                c_reg[c]  <= c_next[c];
                v_reg[c]  <= v_next[c];
                p_reg[c]  <= p_next[c];
                t_reg[c]  <= t_next[c];
                v1_reg[c] <= v_reg[c];
                a_reg[c]  <= a_next[c];
                tr_reg[c] <= tr_next[c];
                v2_reg[c] <= v1_reg[c];
                bp_reg[c] <= bp_next[c];
                a2_reg[c] <= a_reg[c];
                f_reg[c]  <= f_next[c];
                o_reg[c]  <= o_next[c];
                lp_reg[c] <= lp_next[c];
                for (int k = 0; k < 3; k++)
                begin
                    ip_reg[c][k] <= ip_next[c][k];
                    op_reg[c][k] <= op_next[c][k];
                end
                for (int j = 0; j <= QUO_W; j++)
                begin
                    dv_r_reg[j][c]   <= dv_r_next[j][c];
                    dv_b_reg[j][c]   <= dv_b_next[j][c];
                    dv_q_reg[j][c]   <= dv_q_next[j][c];
                    dv_neg_reg[j][c] <= dv_neg_next[j][c];
                end
            end
            for (int j = 0; j <= ROOT_W; j++)
            begin
                sq_rem_reg[j]  <= sq_rem_next[j];
                sq_root_reg[j] <= sq_root_next[j];
            end
            luma_reg <= luma_next;
        end
    end

    assign luma = luma_reg;

endmodule

// ===== rtl/core/aces_synthetic_exposure_luma.sv =====
// Throughput one item per cycle while the skid entry is empty; in_ready drops while it is full.
// The pipeline moves as a whole; a two-entry output buffer (output register plus
// skid) lets it keep taking items while a finished result waits to be taken.
// The 18-step curve divider and 17-step square root set the depth.
// Reset clears valid bits and loads gains to 1.0, 2.0 and 0.5; payload is not reset.
// Uses aces_pkg and aces_lane.
`timescale 1ns / 1ps

module aces_synthetic_exposure_luma
    import aces_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pixel_t            in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output luma_t             out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [GAIN_W-1:0] cfg_data
);

    logic signed [GAIN_W-1:0]   exposure_gain_reg;
    logic signed [GAIN_W-1:0]   highlight_gain_reg;
    logic signed [SHADOW_W-1:0] shadow_gain_reg;

    logic [PIPE_STAGES-1:0]     vld_reg;
    logic [PIPE_STAGES-1:0]     vld_next;
    logic                       en;

    logic signed [BASE_W-1:0]   base_reg [3];
    logic signed [BASE_W-1:0]   base_next [3];

    luma_t                      pipe_data;
    logic                       up_acc;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    luma_t                      out_data_reg;
    luma_t                      out_data_next;
    logic                       skid_valid_reg;
    logic                       skid_valid_next;
    luma_t                      skid_data_reg;
    luma_t                      skid_data_next;

    // config: user must rewrite gains only while the block is idle; the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exposure_gain_reg  <= EXPOSURE_RESET;
            highlight_gain_reg <= HIGHLIGHT_RESET;
            shadow_gain_reg    <= SHADOW_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_EXPOSURE:  exposure_gain_reg  <= $signed(cfg_data);
                REG_HIGHLIGHT: highlight_gain_reg <= $signed(cfg_data);
                REG_SHADOW:    shadow_gain_reg    <= $signed(cfg_data[SHADOW_W-1:0]);
                default:       ;
            endcase
        end
    end

    // whole pipe advances unless the skid entry is occupied
    assign en       = !skid_valid_reg;
    assign in_ready = en;
    assign up_acc   = vld_reg[PIPE_STAGES-1] && en;

    always_comb
    begin
        vld_next = {vld_reg[PIPE_STAGES-2:0], in_valid};
        base_next[0] = $signed({1'b0, in_data.red})   * exposure_gain_reg;
        base_next[1] = $signed({1'b0, in_data.green}) * exposure_gain_reg;
        base_next[2] = $signed({1'b0, in_data.blue})  * exposure_gain_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                base_reg[c] <= base_next[c];
            end
        end
    end

    // three exposure copies share the scaled base pixel
    aces_lane u_lane_hl (
        .clk  (clk),
        .en   (en),
        .base (base_reg),
        .gain (highlight_gain_reg),
        .luma (pipe_data.luma_highlights)
    );

    aces_lane u_lane_mid (
        .clk  (clk),
        .en   (en),
        .base (base_reg),
        .gain (UNITY_GAIN),
        .luma (pipe_data.luma_midtones)
    );

    aces_lane u_lane_sh (
        .clk  (clk),
        .en   (en),
        .base (base_reg),
        .gain (GAIN_W'(shadow_gain_reg)),
        .luma (pipe_data.luma_shadows)
    );

    // output register with skid; skid only fills while the output is stalled
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && !out_ready)
        begin
            if (up_acc)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = pipe_data;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = up_acc;
            out_data_next  = pipe_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // items in flight are conserved across accept and delivery
    a_occ_up: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !(out_valid && out_ready)) |=>
        ($countones({vld_reg, out_valid_reg, skid_valid_reg}) ==
         $past($countones({vld_reg, out_valid_reg, skid_valid_reg})) + 1))
        else $error("occupancy did not grow on accept");

    a_occ_down: assert property (@(posedge clk) disable iff (!rst_n)
        (!(in_valid && in_ready) && out_valid && out_ready) |=>
        ($countones({vld_reg, out_valid_reg, skid_valid_reg}) ==
         $past($countones({vld_reg, out_valid_reg, skid_valid_reg})) - 1))
        else $error("occupancy did not shrink on delivery");

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output item");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid entry not moved to output");

endmodule
